/* src/sse_pkg.sv */
`default_nettype none
package sse_pkg;

	// default geometry
	localparam int SSE_DEPTH        = 1024;
	localparam int SSE_FRAC_BITS    = 16;
	localparam int SSE_SAMPLE_WIDTH = 23;

	// fixed field widths
	localparam int FUNC_W = 4;
	localparam int RES_W  = 30;
	localparam int STAT_W = 2;

	localparam logic [RES_W-1:0] RES_MAX = '1;

	// command codes
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 4'd0;
	localparam logic [FUNC_W-1:0] FN_LOAD   = 4'd1;
	localparam logic [FUNC_W-1:0] FN_MIN    = 4'd2;
	localparam logic [FUNC_W-1:0] FN_MAX    = 4'd3;
	localparam logic [FUNC_W-1:0] FN_MEAN   = 4'd4;
	localparam logic [FUNC_W-1:0] FN_FIND   = 4'd5;
	localparam logic [FUNC_W-1:0] FN_COUNT  = 4'd6;
	localparam logic [FUNC_W-1:0] FN_MEDIAN = 4'd7;
	localparam logic [FUNC_W-1:0] FN_MODE   = 4'd8;
	localparam logic [FUNC_W-1:0] FN_RANGE  = 4'd9;
	localparam logic [FUNC_W-1:0] FN_STDDEV = 4'd10;
	localparam logic [FUNC_W-1:0] FN_VAR    = 4'd11;
	localparam logic [FUNC_W-1:0] FN_SORT   = 4'd12;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

endpackage
`default_nettype wire

/* src/sse_ifs.sv */
`default_nettype none
interface sse_req_if import sse_pkg::*; #(
	parameter int SAMPLE_WIDTH = SSE_SAMPLE_WIDTH
);
	logic                    valid;
	logic                    ready;
	logic [FUNC_W-1:0]       func;
	logic [SAMPLE_WIDTH-1:0] value;

	modport source (output valid, func, value, input ready);
	modport sink   (input valid, func, value, output ready);
endinterface

interface sse_rsp_if import sse_pkg::*; #(
	parameter int IDX_W = 10,
	parameter int CNT_W = 11
);
	logic              valid;
	logic              ready;
	logic [RES_W-1:0]  result_value;
	logic              found;
	logic [IDX_W-1:0]  position;
	logic [CNT_W-1:0]  tally;
	logic [STAT_W-1:0] status;

	modport source (output valid, result_value, found, position, tally, status, input ready);
	modport sink   (input valid, result_value, found, position, tally, status, output ready);
endinterface
`default_nettype wire

/* src/sample_statistics_engine_core.sv */
// Descriptive statistics over a stored set of unsigned fixed-point samples.
// req channel: one request carries a command (func) and a sample or search
// value. rsp channel: one response per request with result_value, found,
// position, tally and status.
// Clear, load, unknown commands and any query on an empty set answer at the
// edge that takes the request: the response is valid in the next cycle, and
// the next request can be taken then. Loads therefore stream at one per
// cycle while the receiver keeps up.
// Queries walk the store through its single read port, one sample at a time.
// Mean, variance and std deviation divide the sum in a bit-serial divider of
// width W = 2*SAMPLE_WIDTH+clog2(DEPTH+1); variance and std deviation add a
// pass over squared deviations, and std deviation a digit-by-digit square root.
// Sort and a median on an unsorted store run an exchange sort.
// The block takes no request while a query runs, nor while a response waits
// and the receiver stalls; the response register simply holds.
// Reset empties the set and clears the sorted mark; stored sample values are
// not cleared and are never read beyond the fill count.
`default_nettype none
module sample_statistics_engine_core import sse_pkg::*; #(
	parameter int DEPTH        = SSE_DEPTH,
	parameter int FRAC_BITS    = SSE_FRAC_BITS,
	parameter int SAMPLE_WIDTH = SSE_SAMPLE_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	sse_req_if.sink    req,
	sse_rsp_if.source  rsp
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int VSUM_W = 2 * SW + CNT_W;
	localparam int EXT_W  = (VSUM_W > RES_W) ? VSUM_W : RES_W;
	localparam int ISQ_W  = VSUM_W + (VSUM_W % 2);
	localparam int DC_W   = $clog2(VSUM_W + 1);
	localparam int KEY_W  = SW + 4;

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_EX, S_SCAN_ACC, S_DIV, S_SQRT,
		S_SORT_IRD, S_SORT_IEX, S_SORT_JRD, S_SORT_JEX, S_SORT_IWR,
		S_MED_ARD, S_MED_AEX, S_MED_BRD, S_MED_BEX,
		S_MODE_IRD, S_MODE_IEX, S_MODE_JRD, S_MODE_JEX
	} state_t;

	state_t             state_q;
	logic [FUNC_W-1:0]  cmd_q;
	logic [SW-1:0]      val_q;
	logic [CNT_W-1:0]   fill_q;
	logic               sorted_q;
	logic [CNT_W-1:0]   idx_q, i_q, j_q;
	logic [SW-1:0]      mn_q, mx_q, mean_q, ai_q, cand_q, best_q, meda_q;
	logic               pass_q;
	logic [VSUM_W-1:0]  acc_q;
	logic [2*SW-1:0]    sq_s1;
	logic [VSUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]   rem_q;
	logic [DC_W-1:0]    dcnt_q;
	logic [ISQ_W-1:0]   sx_q, sres_q, sbit_q;
	logic [CNT_W-1:0]   cnt_q, bc_q;
	logic               sfound_q;
	logic [IDX_W-1:0]   spos_q;
	logic [CNT_W-1:0]   stally_q;

	// response register
	logic               ov_q;
	logic [RES_W-1:0]   ores_q;
	logic               ofound_q;
	logic [IDX_W-1:0]   opos_q;
	logic [CNT_W-1:0]   otally_q;
	logic [STAT_W-1:0]  ost_q;

	// sample store
	logic [SW-1:0]      mem [DEPTH];
	logic [SW-1:0]      rdata_q;
	logic [IDX_W-1:0]   raddr, waddr;
	logic [SW-1:0]      wdata;
	logic               we;

	function automatic logic [KEY_W-1:0] key_of(input logic [SW-1:0] s);
		logic [KEY_W-1:0] p;
		p = {1'b0, s, 3'b000} + {2'b00, s, 1'b0};
		return p >> FRAC_BITS;
	endfunction

	function automatic logic [RES_W-1:0] sat_res(input logic [EXT_W-1:0] v);
		if (v > EXT_W'(RES_MAX))
			return RES_MAX;
		return v[RES_W-1:0];
	endfunction

	logic accept, load_ok, last_idx, last_j, swap;
	assign accept   = req.valid && req.ready;
	assign load_ok  = fill_q < CNT_W'(DEPTH);
	assign last_idx = idx_q == fill_q - 1'b1;
	assign last_j   = j_q == fill_q - 1'b1;
	assign swap     = key_of(ai_q) > key_of(rdata_q);

	assign req.ready = (state_q == S_IDLE) && (!ov_q || rsp.ready);

	assign rsp.valid        = ov_q;
	assign rsp.result_value = ores_q;
	assign rsp.found        = ofound_q;
	assign rsp.position     = opos_q;
	assign rsp.tally        = otally_q;
	assign rsp.status       = ost_q;

	// store address and write select
	always_comb begin
		unique case (state_q)
			S_SORT_IRD, S_MODE_IRD: raddr = i_q[IDX_W-1:0];
			S_SORT_JRD, S_MODE_JRD: raddr = j_q[IDX_W-1:0];
			S_MED_ARD:              raddr = IDX_W'((fill_q - 1'b1) >> 1);
			S_MED_BRD:              raddr = IDX_W'(fill_q >> 1);
			default:                raddr = idx_q[IDX_W-1:0];
		endcase
		we    = 1'b0;
		waddr = fill_q[IDX_W-1:0];
		wdata = req.value;
		if (accept && req.func == FN_LOAD && load_ok) begin
			we = 1'b1;
		end else if (state_q == S_SORT_JEX && swap) begin
			we    = 1'b1;
			waddr = j_q[IDX_W-1:0];
			wdata = ai_q;
		end else if (state_q == S_SORT_IWR) begin
			we    = 1'b1;
			waddr = i_q[IDX_W-1:0];
			wdata = ai_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// scan step values
	logic [SW-1:0]     mn_nx, mx_nx, dev;
	logic              hit, found_nx;
	logic [IDX_W-1:0]  pos_nx;
	logic [CNT_W-1:0]  tally_nx, cnt_nx;
	logic [VSUM_W-1:0] acc_nx;
	always_comb begin
		mn_nx    = (idx_q == '0 || rdata_q < mn_q) ? rdata_q : mn_q;
		mx_nx    = (idx_q == '0 || rdata_q > mx_q) ? rdata_q : mx_q;
		hit      = rdata_q == val_q;
		found_nx = sfound_q || hit;
		pos_nx   = (hit && !sfound_q) ? idx_q[IDX_W-1:0] : spos_q;
		tally_nx = stally_q + CNT_W'(hit);
		acc_nx   = acc_q + VSUM_W'(rdata_q);
		dev      = (rdata_q >= mean_q) ? rdata_q - mean_q : mean_q - rdata_q;
		cnt_nx   = cnt_q + CNT_W'(rdata_q == cand_q);
	end

	// shared divider step: one quotient bit per cycle, divisor is the fill count
	logic [CNT_W:0]    dtmp, drem;
	logic              dge;
	logic [VSUM_W-1:0] qnx;
	always_comb begin
		dtmp = {rem_q, dvd_q[VSUM_W-1]};
		dge  = dtmp >= {1'b0, fill_q};
		drem = dge ? dtmp - {1'b0, fill_q} : dtmp;
		qnx  = {dvd_q[VSUM_W-2:0], dge};
	end

	// square root step: two radicand bits per cycle
	logic [ISQ_W-1:0] strial, sres_nx;
	logic             sge;
	always_comb begin
		strial  = sres_q + sbit_q;
		sge     = sx_q >= strial;
		sres_nx = sge ? (sres_q >> 1) + sbit_q : sres_q >> 1;
	end

	logic mode_better;
	assign mode_better = (i_q == '0) || (cnt_nx > bc_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			sorted_q <= 1'b0;
			ov_q     <= 1'b0;
			cmd_q    <= FN_CLEAR;
			val_q    <= '0;
			idx_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			pass_q   <= 1'b0;
			dcnt_q   <= '0;
			ores_q   <= '0;
			ofound_q <= 1'b0;
			opos_q   <= '0;
			otally_q <= '0;
			ost_q    <= ST_OK;
		end else begin
			if (ov_q && rsp.ready)
				ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= req.func;
						val_q    <= req.value;
						ores_q   <= '0;
						ofound_q <= 1'b0;
						opos_q   <= '0;
						otally_q <= '0;
						ost_q    <= ST_OK;
						idx_q    <= '0;
						i_q      <= '0;
						pass_q   <= 1'b0;
						acc_q    <= '0;
						sfound_q <= 1'b0;
						spos_q   <= '0;
						stally_q <= '0;
						if (req.func > FN_SORT) begin
							ost_q <= ST_UNKNOWN;
							ov_q  <= 1'b1;
						end else if (req.func == FN_CLEAR) begin
							fill_q   <= '0;
							sorted_q <= 1'b0;
							ov_q     <= 1'b1;
						end else if (req.func == FN_LOAD) begin
							if (load_ok) begin
								fill_q   <= fill_q + 1'b1;
								sorted_q <= 1'b0;
							end else begin
								ost_q <= ST_FULL;
							end
							ov_q <= 1'b1;
						end else if (fill_q == '0) begin
							ost_q <= ST_EMPTY;
							ov_q  <= 1'b1;
						end else begin
							case (req.func) inside
								FN_SORT:   state_q <= S_SORT_IRD;
								FN_MEDIAN: state_q <= sorted_q ? S_MED_ARD : S_SORT_IRD;
								FN_MODE:   state_q <= S_MODE_IRD;
								default:   state_q <= S_SCAN_RD;
							endcase
						end
					end
				end

				S_SCAN_RD: state_q <= S_SCAN_EX;

				S_SCAN_EX: begin
					mn_q     <= mn_nx;
					mx_q     <= mx_nx;
					sfound_q <= found_nx;
					spos_q   <= pos_nx;
					stally_q <= tally_nx;
					if (pass_q) begin
						sq_s1   <= dev * dev;
						state_q <= S_SCAN_ACC;
					end else begin
						acc_q <= acc_nx;
						idx_q <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
						if (last_idx) begin
							state_q <= S_IDLE;
							ov_q    <= 1'b1;
							case (cmd_q) inside
								FN_MIN:   ores_q <= sat_res(EXT_W'(mn_nx));
								FN_MAX:   ores_q <= sat_res(EXT_W'(mx_nx));
								FN_RANGE: ores_q <= sat_res(EXT_W'(mx_nx - mn_nx));
								FN_FIND, FN_COUNT: begin
									ofound_q <= found_nx;
									opos_q   <= pos_nx;
									otally_q <= tally_nx;
								end
								default: begin
									// mean, variance, std deviation: divide the sum
									ov_q    <= 1'b0;
									dvd_q   <= acc_nx;
									rem_q   <= '0;
									dcnt_q  <= '0;
									state_q <= S_DIV;
								end
							endcase
						end
					end
				end

				S_SCAN_ACC: begin
					acc_q <= acc_q + VSUM_W'(sq_s1);
					idx_q <= idx_q + 1'b1;
					if (last_idx) begin
						dvd_q   <= acc_q + VSUM_W'(sq_s1);
						rem_q   <= '0;
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end

				S_DIV: begin
					rem_q  <= drem[CNT_W-1:0];
					dvd_q  <= qnx;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DC_W'(VSUM_W - 1)) begin
						if (cmd_q == FN_MEAN) begin
							ores_q  <= sat_res(EXT_W'(qnx));
							ov_q    <= 1'b1;
							state_q <= S_IDLE;
						end else if (!pass_q) begin
							mean_q  <= qnx[SW-1:0];
							pass_q  <= 1'b1;
							acc_q   <= '0;
							idx_q   <= '0;
							state_q <= S_SCAN_RD;
						end else if (cmd_q == FN_VAR) begin
							ores_q  <= sat_res(EXT_W'(qnx >> FRAC_BITS));
							ov_q    <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							sx_q    <= ISQ_W'(qnx);
							sres_q  <= '0;
							sbit_q  <= ISQ_W'(1) << (ISQ_W - 2);
							state_q <= S_SQRT;
						end
					end
				end

				S_SQRT: begin
					if (sge)
						sx_q <= sx_q - strial;
					sres_q <= sres_nx;
					sbit_q <= sbit_q >> 2;
					if (sbit_q == ISQ_W'(1)) begin
						ores_q  <= sat_res(EXT_W'(sres_nx));
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end

				// exchange sort: the candidate for a[i] stays in ai_q across the inner pass
				S_SORT_IRD: begin
					if ({1'b0, i_q} + 1'b1 >= {1'b0, fill_q}) begin
						sorted_q <= 1'b1;
						if (cmd_q == FN_MEDIAN) begin
							state_q <= S_MED_ARD;
						end else begin
							ov_q    <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_SORT_IEX;
					end
				end
				S_SORT_IEX: begin
					ai_q    <= rdata_q;
					j_q     <= i_q + 1'b1;
					state_q <= S_SORT_JRD;
				end
				S_SORT_JRD: state_q <= S_SORT_JEX;
				S_SORT_JEX: begin
					if (swap)
						ai_q <= rdata_q;
					j_q     <= j_q + 1'b1;
					state_q <= last_j ? S_SORT_IWR : S_SORT_JRD;
				end
				S_SORT_IWR: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_SORT_IRD;
				end

				// median: average of the middle pair (same element when n is odd)
				S_MED_ARD: state_q <= S_MED_AEX;
				S_MED_AEX: begin
					meda_q  <= rdata_q;
					state_q <= S_MED_BRD;
				end
				S_MED_BRD: state_q <= S_MED_BEX;
				S_MED_BEX: begin
					ores_q  <= sat_res(EXT_W'(({1'b0, meda_q} + {1'b0, rdata_q}) >> 1));
					ov_q    <= 1'b1;
					state_q <= S_IDLE;
				end

				// mode: count each candidate over the whole set, earliest wins ties
				S_MODE_IRD: state_q <= S_MODE_IEX;
				S_MODE_IEX: begin
					cand_q  <= rdata_q;
					j_q     <= '0;
					cnt_q   <= '0;
					state_q <= S_MODE_JRD;
				end
				S_MODE_JRD: state_q <= S_MODE_JEX;
				S_MODE_JEX: begin
					cnt_q <= cnt_nx;
					j_q   <= j_q + 1'b1;
					state_q <= S_MODE_JRD;
					if (last_j) begin
						if (mode_better) begin
							bc_q   <= cnt_nx;
							best_q <= cand_q;
						end
						i_q     <= i_q + 1'b1;
						state_q <= S_MODE_IRD;
						if (i_q == fill_q - 1'b1) begin
							ores_q  <= sat_res(EXT_W'(mode_better ? cand_q : best_q));
							ov_q    <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count beyond store depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> fill_q == CNT_W'(DEPTH))
		else $error("store-full status while store not full");

	a_found_tally: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.tally != '0)
		else $error("found without matching samples");

	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT |-> $onehot0(sbit_q))
		else $error("square root bit not one-hot");

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none
module tb_top;
	import sse_pkg::*;

	localparam int N_RANDOM = 370;
	localparam int SW = SSE_SAMPLE_WIDTH;
	localparam logic [SW-1:0] VAL_MAX = '1;

	// codes outside the command set
	localparam logic [FUNC_W-1:0] FN_BAD_LO = 4'd13;
	localparam logic [FUNC_W-1:0] FN_BAD_HI = 4'd15;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SW-1:0]     value;
	} cmd_t;

	typedef struct packed {
		logic [RES_W-1:0]  result_value;
		logic              found;
		logic [9:0]        position;
		logic [10:0]       tally;
		logic [STAT_W-1:0] status;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sse_req_if req_ch ();
	sse_rsp_if rsp_ch ();

	sample_statistics_engine_core DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #10 clk = ~clk;

	// shadow copy of the sample set
	logic [SW-1:0] shadow [SSE_DEPTH];
	int unsigned   shadow_n = 0;
	bit            shadow_sorted = 0;

	cmd_t    cmd_queue [$];
	answer_t answer_queue [$];
	int      total_cmds = 0;
	int      accepted = 0;
	int      responses = 0;
	int      mismatches = 0;
	int      send_idle;
	int      recv_idle;
	cmd_t    next_cmd;

	function automatic longint unsigned order_key(logic [SW-1:0] s);
		return (longint'(s) * 10) >> SSE_FRAC_BITS;
	endfunction

	function automatic void sort_shadow();
		logic [SW-1:0] t;
		for (int i = 0; i + 1 < shadow_n; i++)
			for (int j = i + 1; j < shadow_n; j++)
				if (order_key(shadow[i]) > order_key(shadow[j])) begin
					t = shadow[i];
					shadow[i] = shadow[j];
					shadow[j] = t;
				end
		shadow_sorted = 1;
	endfunction

	function automatic longint unsigned sq_dev_mean();
		longint unsigned sum, m, d, acc;
		sum = 0;
		acc = 0;
		for (int i = 0; i < shadow_n; i++) sum += shadow[i];
		m = sum / shadow_n;
		for (int i = 0; i < shadow_n; i++) begin
			d = (shadow[i] >= m) ? shadow[i] - m : m - shadow[i];
			acc += d * d;
		end
		return acc / shadow_n;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [RES_W-1:0] clip30(longint unsigned v);
		return (v > longint'(RES_MAX)) ? RES_MAX : v[RES_W-1:0];
	endfunction

	// expected response for one request; updates the shadow set
	function automatic answer_t predict_stats(logic [FUNC_W-1:0] f, logic [SW-1:0] v);
		answer_t a;
		longint unsigned res, sum;
		logic [SW-1:0] mn, mx;
		int unsigned best, bc, c, tl;
		a = '0;
		res = 0;
		if (f > FN_SORT) begin
			a.status = ST_UNKNOWN;
		end else if (f == FN_CLEAR) begin
			shadow_n = 0;
			shadow_sorted = 0;
		end else if (f == FN_LOAD) begin
			if (shadow_n < SSE_DEPTH) begin
				shadow[shadow_n] = v;
				shadow_n++;
				shadow_sorted = 0;
			end else begin
				a.status = ST_FULL;
			end
		end else if (shadow_n == 0) begin
			a.status = ST_EMPTY;
		end else begin
			mn = shadow[0];
			mx = shadow[0];
			sum = 0;
			for (int i = 0; i < shadow_n; i++) begin
				if (shadow[i] < mn) mn = shadow[i];
				if (shadow[i] > mx) mx = shadow[i];
				sum += shadow[i];
			end
			case (f)
				FN_MIN: res = mn;
				FN_MAX: res = mx;
				FN_MEAN: res = sum / shadow_n;
				FN_FIND, FN_COUNT: begin
					tl = 0;
					for (int i = 0; i < shadow_n; i++)
						if (shadow[i] == v) begin
							if (tl == 0) a.position = i[9:0];
							tl++;
						end
					a.found = (tl != 0);
					a.tally = tl[10:0];
				end
				FN_MEDIAN: begin
					if (!shadow_sorted) sort_shadow();
					if (shadow_n[0]) res = shadow[shadow_n / 2];
					else res = (longint'(shadow[shadow_n/2 - 1]) + shadow[shadow_n/2]) >> 1;
				end
				FN_MODE: begin
					best = 0;
					bc = 0;
					for (int i = 0; i < shadow_n; i++) begin
						c = 0;
						for (int j = 0; j < shadow_n; j++) if (shadow[j] == shadow[i]) c++;
						if (i == 0 || c > bc) begin
							bc = c;
							best = i;
						end
					end
					res = shadow[best];
				end
				FN_RANGE: res = mx - mn;
				FN_STDDEV: res = floor_sqrt(sq_dev_mean());
				FN_VAR: res = sq_dev_mean() >> SSE_FRAC_BITS;
				default: sort_shadow();
			endcase
		end
		a.result_value = clip30(res);
		return a;
	endfunction

	// idle ratios per third of the run
	always_comb begin
		if (accepted * 3 < total_cmds) begin
			send_idle = 36;
			recv_idle = 63;
		end else if (accepted * 3 < total_cmds * 2) begin
			send_idle = 63;
			recv_idle = 36;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	end

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				answer_queue.push_back(predict_stats(req_ch.func, req_ch.value));
				accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
					next_cmd = cmd_queue.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.func  <= next_cmd.func;
					req_ch.value <= next_cmd.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				responses++;
				if (answer_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response with nothing expected: value %0d status %0d",
							rsp_ch.result_value, rsp_ch.status);
				end else if (rsp_ch.result_value !== answer_queue[0].result_value
						|| rsp_ch.found !== answer_queue[0].found
						|| rsp_ch.position !== answer_queue[0].position
						|| rsp_ch.tally !== answer_queue[0].tally
						|| rsp_ch.status !== answer_queue[0].status) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch at response %0d: ",
							"exp val %0d f %0d pos %0d n %0d st %0d, ",
							"got val %0d f %0d pos %0d n %0d st %0d"},
							responses, answer_queue[0].result_value, answer_queue[0].found,
							answer_queue[0].position, answer_queue[0].tally,
							answer_queue[0].status, rsp_ch.result_value, rsp_ch.found,
							rsp_ch.position, rsp_ch.tally, rsp_ch.status);
					void'(answer_queue.pop_front());
				end else begin
					void'(answer_queue.pop_front());
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	function automatic void add_cmd(logic [FUNC_W-1:0] f, logic [SW-1:0] v);
		cmd_t c;
		c.func = f;
		c.value = v;
		cmd_queue.push_back(c);
		total_cmds++;
	endfunction

	// sample values with duplicates, sort key ties and extremes
	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return SW'($urandom());
			1: return SW'($urandom_range(0, 7) << 13);
			2: return SW'(($urandom_range(0, 3) << 16) + $urandom_range(0, 6000));
			3: return VAL_MAX - SW'($urandom_range(0, 3));
			4: return SW'($urandom_range(0, 3));
			default: return SW'($urandom_range(0, 8) * 20000);
		endcase
	endfunction

	logic [SW-1:0] loaded [$];
	logic [FUNC_W-1:0] qf;
	int set_len;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.func  = FN_CLEAR;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: empty set, unknown codes, extremes, ties
		add_cmd(FN_MIN, '0);
		add_cmd(FN_SORT, '0);
		add_cmd(FN_BAD_LO, VAL_MAX);
		add_cmd(FN_BAD_HI, '0);
		add_cmd(FN_LOAD, VAL_MAX);
		add_cmd(FN_MEDIAN, '0);
		add_cmd(FN_LOAD, '0);
		add_cmd(FN_LOAD, 23'd6554);
		add_cmd(FN_LOAD, 23'd6555);
		add_cmd(FN_LOAD, 23'd6554);
		add_cmd(FN_LOAD, '0);
		add_cmd(FN_MODE, '0);
		add_cmd(FN_MEDIAN, '0);
		add_cmd(FN_SORT, '0);
		add_cmd(FN_MIN, '0);
		add_cmd(FN_MAX, '0);
		add_cmd(FN_MEAN, '0);
		add_cmd(FN_FIND, 23'd6554);
		add_cmd(FN_COUNT, 23'd7);
		add_cmd(FN_RANGE, '0);
		add_cmd(FN_VAR, '0);
		add_cmd(FN_STDDEV, '0);
		add_cmd(FN_LOAD, 23'd1);
		add_cmd(FN_MEDIAN, '0);
		add_cmd(FN_CLEAR, '0);

		// random small sets followed by queries
		while (total_cmds < N_RANDOM) begin
			loaded.delete();
			add_cmd(FN_CLEAR, SW'($urandom()));
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
				: $urandom_range(2, 30);
			for (int i = 0; i < set_len; i++) begin
				loaded.push_back(pick_sample());
				add_cmd(FN_LOAD, loaded[$]);
			end
			repeat ($urandom_range(2, 10)) begin
				qf = ($urandom_range(0, 19) == 0) ? FUNC_W'($urandom_range(0, 15))
					: FUNC_W'($urandom_range(2, 12));
				if (qf == FN_LOAD) loaded.push_back(pick_sample());
				if (qf == FN_CLEAR) loaded.delete();
				if (qf == FN_LOAD) add_cmd(qf, loaded[$]);
				else if (loaded.size() > 0 && $urandom_range(0, 1))
					add_cmd(qf, loaded[$urandom_range(0, loaded.size() - 1)]);
				else
					add_cmd(qf, SW'($urandom()));
			end
		end

		// full store: dropped load and the cheap walks over every entry
		add_cmd(FN_CLEAR, '0);
		for (int i = 0; i < SSE_DEPTH; i++)
			add_cmd(FN_LOAD, (i == SSE_DEPTH - 1) ? VAL_MAX : pick_sample());
		add_cmd(FN_LOAD, 23'd5);
		add_cmd(FN_FIND, VAL_MAX);
		add_cmd(FN_COUNT, VAL_MAX);
		add_cmd(FN_MIN, '0);
		add_cmd(FN_MEAN, '0);
		add_cmd(FN_RANGE, '0);
		add_cmd(FN_VAR, '0);
		add_cmd(FN_STDDEV, '0);

		wait (cmd_queue.size() == 0);
		do @(posedge clk); while (req_ch.valid || answer_queue.size() != 0);
		repeat (100) @(posedge clk);

		$display("%0d requests issued, %0d responses checked over random sets and a full store",
			accepted, responses);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0 && answer_queue.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		#200000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
src/sse_pkg.sv
src/sse_ifs.sv
src/sample_statistics_engine_core.sv
bench/tb_top.sv
